FILE: rtl/fp16d_pkg.sv
`timescale 1ns / 1ps
package fp16d_pkg;

	localparam int DIV_STEPS = 33;
	localparam int REG_W     = 45;
	localparam int QUOT_W    = 33;
	localparam int MANT_W    = 11;

	localparam logic [15:0] SAT_MAG = 16'h7bff;

	typedef struct packed {
		logic              dz;
		logic              sq;
		logic signed [6:0] eq;
		logic [MANT_W-1:0] md;
	} side_t;

endpackage

FILE: rtl/fp16_divider_unit.sv
`timescale 1ns / 1ps
// Half-precision divider, fully pipelined.
// Pipeline: done rises after decode, 33 divide steps one per stage,
// leading-one search, and round and pack, each registered in turn.
// Throughput: one word per cycle; busy is always low, the receiver cannot stall.
// Reset: arst_n clears all valid bits asynchronously; payload is not reset.
module fp16_divider_unit
	import fp16d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] dividend_bits,
	input  logic [15:0] divisor_bits,
	output logic        done,
	output logic [15:0] quotient_bits
);

	// no backpressure anywhere: a word can enter every cycle
	assign busy = 1'b0;

	// ---------------- stage 1: unpack ----------------
	logic [4:0]        ex, ed;
	logic [9:0]        fx, fd;
	logic [4:0]        ex_eff, ed_eff;
	logic [MANT_W-1:0] mx, md;
	side_t             side_in;

	always_comb begin
		ex = dividend_bits[14:10];
		ed = divisor_bits[14:10];
		fx = dividend_bits[9:0];
		fd = divisor_bits[9:0];
		// denormal: exponent 1, no hidden bit (zero dividend keeps exponent 0)
		if (ex == 5'd0) begin
			ex_eff = (fx != 10'd0) ? 5'd1 : 5'd0;
			mx     = {1'b0, fx};
		end else begin
			ex_eff = ex;
			mx     = {1'b1, fx};
		end
		if (ed == 5'd0) begin
			ed_eff = 5'd1;
			md     = {1'b0, fd};
		end else begin
			ed_eff = ed;
			md     = {1'b1, fd};
		end
		side_in.dz = (divisor_bits[14:0] == 15'd0);
		side_in.sq = dividend_bits[15] ^ divisor_bits[15];
		side_in.eq = $signed({2'b00, ex_eff}) - $signed({2'b00, ed_eff}) + 7'sd15;
		side_in.md = md;
	end

	// ---------------- divide steps ----------------
	// entry 0 is the unpack stage, entry i holds the result of step i
	logic             dv_vld_s [0:DIV_STEPS];
	logic [REG_W-1:0] dv_rem_s [0:DIV_STEPS];
	side_t            dv_side_s[0:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else begin
			dv_vld_s[0] <= start;
		end
	end

	always_ff @(posedge clk) begin
		dv_rem_s[0]  <= {{(REG_W-MANT_W-22){1'b0}}, mx, 22'd0};
		dv_side_s[0] <= side_in;
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [REG_W-1:0] sh, den, nxt;

		always_comb begin
			sh  = {dv_rem_s[i][REG_W-2:0], 1'b0};
			den = {1'b0, dv_side_s[i].md, {QUOT_W{1'b0}}};
			// non-restoring: add when negative, subtract when positive
			nxt = dv_rem_s[i][REG_W-1] ? (sh + den) : (sh - den);
			nxt[0] = ~nxt[REG_W-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[i+1] <= 1'b0;
			end else begin
				dv_vld_s[i+1] <= dv_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			dv_rem_s[i+1]  <= nxt;
			dv_side_s[i+1] <= dv_side_s[i];
		end
	end

	// ---------------- leading-one search ----------------
	logic [QUOT_W-1:0] q;
	logic [4:0]        lz;
	logic              found;
	logic [QUOT_W-1:0] qn;
	logic signed [6:0] enew_c;

	always_comb begin
		q     = dv_rem_s[DIV_STEPS][QUOT_W-1:0];
		lz    = 5'd0;
		found = 1'b0;
		// bits 32 down to 11
		for (int p = 32; p >= 11; p--) begin
			if (!found && q[p]) begin
				found = 1'b1;
				lz    = 5'(32 - p);
			end
		end
		qn     = q << lz;
		enew_c = dv_side_s[DIV_STEPS].eq + 7'sd10 - $signed({2'b00, lz});
	end

	logic              lo_vld_s;
	logic              lo_dz_s, lo_sq_s;
	logic [MANT_W-1:0] lo_mant_s;
	logic              lo_rnd_s;
	logic signed [6:0] lo_exp_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_vld_s <= 1'b0;
		end else begin
			lo_vld_s <= dv_vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		lo_dz_s   <= dv_side_s[DIV_STEPS].dz;
		lo_sq_s   <= dv_side_s[DIV_STEPS].sq;
		lo_mant_s <= found ? qn[32:22] : '0;
		lo_rnd_s  <= found ? qn[21] : 1'b0;
		lo_exp_s  <= found ? enew_c : 7'sd0;
	end

	// ---------------- denormalize, round, pack ----------------
	logic [3:0]        k;
	logic [MANT_W-1:0] m_sh;
	logic              rnd;
	logic [MANT_W:0]   m_rd;
	logic signed [6:0] e_fin;
	logic [9:0]        frac;
	logic [15:0]       res;

	always_comb begin
		k     = 4'd0;
		m_sh  = lo_mant_s;
		rnd   = lo_rnd_s;
		e_fin = lo_exp_s;
		if (lo_exp_s <= 7'sd0) begin
			if (lo_exp_s >= -7'sd10) begin
				k    = 4'(-lo_exp_s);
				rnd  = lo_mant_s[k];
				m_sh = lo_mant_s >> (k + 4'd1);
			end else begin
				rnd  = 1'b0;
				m_sh = '0;
			end
			e_fin = 7'sd0;
		end
		m_rd = {1'b0, m_sh} + {{MANT_W{1'b0}}, rnd};
		frac = m_rd[9:0];
		if (e_fin > 7'sd0) begin
			// rounding carry out of the significand
			if (m_rd[11]) begin
				frac  = m_rd[10:1];
				e_fin = e_fin + 7'sd1;
			end
		end else if (m_rd[10]) begin
			e_fin = 7'sd1;
		end
		if (lo_dz_s) begin
			res = SAT_MAG;
		end else if (e_fin > 7'sd30) begin
			res = {lo_sq_s, SAT_MAG[14:0]};
		end else if (m_rd == '0) begin
			res = 16'h0000;
		end else begin
			res = {lo_sq_s, e_fin[4:0], frac};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= lo_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		quotient_bits <= res;
	end

endmodule
